// ----- src/stack_calculator_assert.svh -----
// assertion macros used by the stack calculator back end
// expects clk and arst_n in the scope of each use
`ifndef STACK_CALCULATOR_ASSERT_SVH
`define STACK_CALCULATOR_ASSERT_SVH

// same-cycle implication
`define SC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/stkc_pkg.sv -----
// stack calculator package: sizes, command and error codes, request and response types
// no dependencies
`timescale 1ns / 1ps

package stkc_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int POS_W       = 10;
	localparam int COUNT_OUT_W = 11;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_STEPS   = DATA_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		CMD_PUSH     = 3'd0,
		CMD_POP      = 3'd1,
		CMD_PEEK_TOP = 3'd2,
		CMD_PEEK_BOT = 3'd3,
		CMD_ADD      = 3'd4,
		CMD_SUB      = 3'd5,
		CMD_MUL      = 3'd6,
		CMD_DIV      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_FULL    = 3'd1,
		ERR_EMPTY   = 3'd2,
		ERR_INDEX   = 3'd3,
		ERR_FEW     = 3'd4,
		ERR_DIVZERO = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_PEEK_TOP,
		OP_PEEK_BOT,
		OP_ARITH
	} op_kind_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_DIV,
		ST_FINISH
	} back_state_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] push_value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		err_t                     error_code;
		logic [COUNT_OUT_W-1:0]   stack_count;
	} rsp_t;

	typedef struct packed {
		op_kind_t                 kind;
		alu_op_t                  alu;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- src/stkc_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module stkc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- src/stkc_div.sv -----
// iterative floor divider, one quotient bit per cycle
// depends on stkc_pkg
`timescale 1ns / 1ps

module stkc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [stkc_pkg::DATA_W-1:0] dividend,
	input  logic [stkc_pkg::DATA_W-1:0] divisor,
	output stkc_pkg::div_stat_t       stat,
	output logic [stkc_pkg::DATA_W-1:0] quotient
);

	import stkc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic                 neg_q;

	logic [DATA_W-1:0] dvd_mag;
	logic [DATA_W-1:0] dvs_mag;
	logic [DATA_W-1:0] rem_sh;
	logic [DATA_W:0]   diff;
	logic              take;

	assign dvd_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign dvs_mag = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
	assign rem_sh  = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
	assign diff    = {1'b0, rem_sh} - {1'b0, dvs_q};
	assign take    = !diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd_mag;
			dvs_q <= dvs_mag;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= take ? diff[DATA_W-1:0] : rem_sh;
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	// floor rounding: with a remainder and mixed signs, -q-1 is ~q
	always_comb begin
		if (!neg_q) begin
			quotient = quo_q;
		end else if (rem_q != '0) begin
			quotient = ~quo_q;
		end else begin
			quotient = ~quo_q + 1'b1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- src/stkc_front.sv -----
// front end: takes requests, classifies commands and queues them for the back end
// depends on stkc_pkg
`timescale 1ns / 1ps

module stkc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  stkc_pkg::req_t   req,
	output logic             q_valid,
	input  logic             q_pop,
	output stkc_pkg::entry_t q_entry
);

	import stkc_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              push;
	logic              pop;

	function automatic entry_t classify(req_t r);
		entry_t e;
		e.value    = r.push_value;
		e.position = r.position;
		e.alu      = ALU_ADD;
		unique case (r.cmd)
			CMD_PUSH:     e.kind = OP_PUSH;
			CMD_POP:      e.kind = OP_POP;
			CMD_PEEK_TOP: e.kind = OP_PEEK_TOP;
			CMD_PEEK_BOT: e.kind = OP_PEEK_BOT;
			CMD_ADD: begin
				e.kind = OP_ARITH;
				e.alu  = ALU_ADD;
			end
			CMD_SUB: begin
				e.kind = OP_ARITH;
				e.alu  = ALU_SUB;
			end
			CMD_MUL: begin
				e.kind = OP_ARITH;
				e.alu  = ALU_MUL;
			end
			default: begin
				e.kind = OP_ARITH;
				e.alu  = ALU_DIV;
			end
		endcase
		return e;
	endfunction

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign req_stall = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid   = (fill_q != '0);
	assign q_entry   = slot_q[rd_ptr_q];
	assign push      = req_valid && !req_stall;
	assign pop       = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= classify(req);
		end
	end

endmodule

// ----- src/stkc_back.sv -----
// back end: executes queued commands against the stack store and drives the response register
// depends on stkc_pkg, stkc_ram, stkc_div and stack_calculator_assert.svh
`timescale 1ns / 1ps
`include "stack_calculator_assert.svh"

module stkc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  stkc_pkg::entry_t q_entry,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output stkc_pkg::rsp_t   rsp
);

	import stkc_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	rsp_t              out_q;

	entry_t            ent_q;
	entry_t            ent_d;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] x_d;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] res_d;
	err_t              err_q;
	err_t              err_d;
	logic [CNT_W-1:0]  ncount_q;
	logic [CNT_W-1:0]  ncount_d;
	logic              wr_pend_q;
	logic              wr_pend_d;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [ADDR_W-1:0] wr_addr_d;

	logic              out_free;
	logic              fin;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic              ram_wr_en;
	logic [DATA_W-1:0] ram_wr_data;
	logic              div_start;
	div_stat_t         div_stat;
	logic [DATA_W-1:0] div_quo;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;

	assign out_free    = !out_valid_q || !rsp_stall;
	assign ram_wr_en   = fin && wr_pend_q;
	// a push stores its own value, arithmetic stores its result
	assign ram_wr_data = (ent_q.kind == OP_PUSH) ? ent_q.value : res_q;
	assign pos_c       = CMP_W'(q_entry.position);
	assign cnt_c       = CMP_W'(count_q);

	stkc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (wr_addr_q),
		.wr_data (ram_wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	stkc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data),
		.divisor  (x_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ent_d     = ent_q;
		x_d       = x_q;
		res_d     = res_q;
		err_d     = err_q;
		ncount_d  = ncount_q;
		wr_pend_d = wr_pend_q;
		wr_addr_d = wr_addr_q;
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		div_start = 1'b0;
		fin       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					ent_d     = q_entry;
					res_d     = '0;
					err_d     = ERR_OK;
					ncount_d  = count_q;
					wr_pend_d = 1'b0;
					state_d   = ST_FINISH;
					unique case (q_entry.kind)
						OP_PUSH: begin
							if (count_q == CNT_W'(STACK_DEPTH)) begin
								err_d = ERR_FULL;
							end else begin
								res_d     = '0;
								wr_pend_d = 1'b1;
								wr_addr_d = ADDR_W'(count_q);
								ncount_d  = count_q + 1'b1;
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								err_d = ERR_EMPTY;
							end else begin
								rd_en    = 1'b1;
								rd_addr  = ADDR_W'(count_q - 1'b1);
								ncount_d = count_q - 1'b1;
								state_d  = ST_RD1;
							end
						end
						OP_PEEK_TOP: begin
							if (pos_c >= cnt_c) begin
								err_d = ERR_INDEX;
							end else begin
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(cnt_c - pos_c - 1'b1);
								state_d = ST_RD1;
							end
						end
						OP_PEEK_BOT: begin
							priority if (pos_c >= CMP_W'(STACK_DEPTH)) begin
								err_d = ERR_INDEX;
							end else if (pos_c < cnt_c) begin
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(pos_c);
								state_d = ST_RD1;
							end
						end
						default: begin
							if (count_q < CNT_W'(2)) begin
								err_d = ERR_FEW;
							end else begin
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(count_q - 1'b1);
								state_d = ST_RD1;
							end
						end
					endcase
				end
			end
			ST_RD1: begin
				if (ent_q.kind == OP_ARITH) begin
					x_d     = rd_data;
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(count_q - CNT_W'(2));
					state_d = ST_RD2;
				end else begin
					res_d   = rd_data;
					state_d = ST_FINISH;
				end
			end
			ST_RD2: begin
				wr_pend_d = 1'b1;
				wr_addr_d = ADDR_W'(count_q - CNT_W'(2));
				ncount_d  = count_q - 1'b1;
				state_d   = ST_FINISH;
				unique case (ent_q.alu)
					ALU_ADD: res_d = rd_data + x_q;
					ALU_SUB: res_d = rd_data - x_q;
					ALU_MUL: res_d = rd_data * x_q;
					default: begin
						if (x_q == '0) begin
							err_d     = ERR_DIVZERO;
							wr_pend_d = 1'b0;
							ncount_d  = count_q - CNT_W'(2);
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
				endcase
			end
			ST_DIV: begin
				if (div_stat.done) begin
					res_d   = div_quo;
					state_d = ST_FINISH;
				end
			end
			default: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin) begin
				count_q     <= ncount_q;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q     <= ent_d;
		x_q       <= x_d;
		res_q     <= res_d;
		err_q     <= err_d;
		ncount_q  <= ncount_d;
		wr_pend_q <= wr_pend_d;
		wr_addr_q <= wr_addr_d;
		if (fin) begin
			out_q.result_value <= res_q;
			out_q.error_code   <= err_q;
			out_q.stack_count  <= COUNT_OUT_W'(ncount_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`SC_ASSERT_IMP(a_count_in_range, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "count beyond depth")
	`SC_ASSERT_IMP(a_write_on_commit, ram_wr_en, state_q == ST_FINISH && err_q == ERR_OK, "store written outside commit")
	`SC_ASSERT_NEXT(a_push_grows, fin && ent_q.kind == OP_PUSH && err_q == ERR_OK, count_q == CNT_W'($past(count_q) + 1'b1), "push did not grow the stack")
	`SC_ASSERT_IMP(a_div_nonzero, div_start, x_q != '0 && !div_stat.busy, "divider started badly")

endmodule

// ----- src/stack_calculator.sv -----
// stack calculator top level: front end, command queue and back end
// depends on stkc_pkg, stkc_front and stkc_back
//
// requests enter on req/req_valid/req_stall, one command each, and every request
// gives exactly one response on rsp/rsp_valid/rsp_stall, in request order.
// the front end holds a two-entry queue; req_stall rises only when it is full.
// push, the full, empty, index and operand errors and a peek bottom above the
// top finish without reading the store. the back end works on one command at a
// time and takes the next one only once it is back in idle; pops and peeks
// otherwise wait for the registered read of the store, arithmetic reads its
// two operands one after the other on the single read port, and divide runs
// 32 steps on the radix-2 divider.
// a stalled response holds in the output register; the back end finishes the
// next command into it only once it is taken, so the queue then fills and
// req_stall is raised.
// reset empties the stack and the queue and drops rsp_valid at once; the store
// itself is not swept, since no slot at or above the count is ever read.
`timescale 1ns / 1ps

module stack_calculator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  stkc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output stkc_pkg::rsp_t rsp
);

	import stkc_pkg::*;

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	stkc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry)
	);

	stkc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
